// ----- sv/cfbc_pkg.sv -----
// cfbc_pkg: shared types and constants for the command frame builder and checker
// depends on nothing; used by cfbc_tx, cfbc_rx and command_frame_builder_checker_top
package cfbc_pkg;

    localparam int FRAME_BYTES = 12;
    localparam int CNT_W       = $clog2(FRAME_BYTES + 1);
    localparam int POS_W       = $clog2(FRAME_BYTES);

    localparam logic [7:0]  HDR0            = 8'h55;
    localparam logic [7:0]  HDR1            = 8'hAA;
    localparam logic [7:0]  ACK_CODE        = 8'h30;
    localparam logic [15:0] DEVICE_ID_RESET = 16'h0001;

    typedef enum logic {
        OP_SEND = 1'b0,
        OP_RECV = 1'b1
    } t_opcode;

    typedef enum logic {
        KIND_TX     = 1'b0,
        KIND_STATUS = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_CSUM = 2'd1,
        ST_NACK = 2'd2
    } t_status;

    // control from the top level to the frame serializer
    typedef struct packed {
        logic load;
        logic advance;
    } t_tx_ctl;

    // serializer status and current byte
    typedef struct packed {
        logic       busy;
        logic       last;
        logic [7:0] data;
    } t_tx_stat;

    // control from the top level to the response checker
    typedef struct packed {
        logic       step;
        logic [7:0] data;
    } t_rx_ctl;

    // checker view: final byte pending, and the status it would give
    typedef struct packed {
        logic        final_byte;
        t_status     status;
        logic [31:0] param;
        logic [15:0] code;
    } t_rx_stat;

endpackage

// ----- sv/cfbc_tx.sv -----
// cfbc_tx: builds a command frame and shifts it out one byte per advance
// depends on cfbc_pkg
module cfbc_tx (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cfbc_pkg::t_tx_ctl  i_ctl,
    input  logic [15:0]        i_device_id,
    input  logic [31:0]        i_cmd_param,
    input  logic [15:0]        i_cmd_code,
    output cfbc_pkg::t_tx_stat o_stat
);

    logic [7:0]                 n_frame [cfbc_pkg::FRAME_BYTES];
    logic [7:0]                 r_frame [cfbc_pkg::FRAME_BYTES];
    logic [cfbc_pkg::CNT_W-1:0] r_left;
    logic [15:0]                sum;

    // checksum is the 16-bit sum of frame bytes 0 to 9, header included
    always_comb begin
        sum = {8'h00, cfbc_pkg::HDR0} + {8'h00, cfbc_pkg::HDR1}
            + {8'h00, i_device_id[7:0]} + {8'h00, i_device_id[15:8]}
            + {8'h00, i_cmd_param[7:0]} + {8'h00, i_cmd_param[15:8]}
            + {8'h00, i_cmd_param[23:16]} + {8'h00, i_cmd_param[31:24]}
            + {8'h00, i_cmd_code[7:0]} + {8'h00, i_cmd_code[15:8]};
    end

    always_comb begin
        n_frame[0]  = cfbc_pkg::HDR0;
        n_frame[1]  = cfbc_pkg::HDR1;
        n_frame[2]  = i_device_id[7:0];
        n_frame[3]  = i_device_id[15:8];
        n_frame[4]  = i_cmd_param[7:0];
        n_frame[5]  = i_cmd_param[15:8];
        n_frame[6]  = i_cmd_param[23:16];
        n_frame[7]  = i_cmd_param[31:24];
        n_frame[8]  = i_cmd_code[7:0];
        n_frame[9]  = i_cmd_code[15:8];
        n_frame[10] = sum[7:0];
        n_frame[11] = sum[15:8];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (i_ctl.load) begin
            r_left <= cfbc_pkg::CNT_W'(cfbc_pkg::FRAME_BYTES);
        end else if (i_ctl.advance) begin
            r_left <= r_left - 1'b1;
        end
    end

    // shift line, byte 0 at the head
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_frame <= n_frame;
        end else if (i_ctl.advance) begin
            for (int i = 0; i < cfbc_pkg::FRAME_BYTES - 1; i++) begin
                r_frame[i] <= r_frame[i+1];
            end
        end
    end

    assign o_stat.busy = (r_left != '0);
    assign o_stat.last = (r_left == cfbc_pkg::CNT_W'(1));
    assign o_stat.data = r_frame[0];

endmodule

// ----- sv/cfbc_rx.sv -----
// cfbc_rx: response frame checker, sums bytes and captures parameter and code
// depends on cfbc_pkg
module cfbc_rx (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cfbc_pkg::t_rx_ctl  i_ctl,
    output cfbc_pkg::t_rx_stat o_stat
);

    logic [cfbc_pkg::POS_W-1:0] r_pos;
    logic [15:0]                r_sum;
    logic [31:0]                r_param;
    logic [15:0]                r_code;
    logic [7:0]                 r_check_low;
    logic                       is_final;
    logic [15:0]                got;
    cfbc_pkg::t_status          status;

    assign is_final = (r_pos >= cfbc_pkg::POS_W'(cfbc_pkg::FRAME_BYTES - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_sum       <= '0;
            r_param     <= '0;
            r_code      <= '0;
            r_check_low <= '0;
        end else if (i_ctl.step) begin
            if (r_pos < cfbc_pkg::POS_W'(cfbc_pkg::FRAME_BYTES - 2)) begin
                r_sum <= r_sum + {8'h00, i_ctl.data};
            end
            if (r_pos >= cfbc_pkg::POS_W'(4) && r_pos <= cfbc_pkg::POS_W'(7)) begin
                r_param <= {i_ctl.data, r_param[31:8]};
            end
            if (r_pos == cfbc_pkg::POS_W'(8) || r_pos == cfbc_pkg::POS_W'(9)) begin
                r_code <= {i_ctl.data, r_code[15:8]};
            end
            if (r_pos == cfbc_pkg::POS_W'(cfbc_pkg::FRAME_BYTES - 2)) begin
                r_check_low <= i_ctl.data;
            end
            if (is_final) begin
                r_pos <= '0;
                r_sum <= '0;
            end else begin
                r_pos <= r_pos + 1'b1;
            end
        end
    end

    assign got = {i_ctl.data, r_check_low};

    // checksum mismatch wins over a negative acknowledge
    always_comb begin
        if (got != r_sum) begin
            status = cfbc_pkg::ST_CSUM;
        end else if (r_code[7:0] != cfbc_pkg::ACK_CODE) begin
            status = cfbc_pkg::ST_NACK;
        end else begin
            status = cfbc_pkg::ST_OK;
        end
    end

    assign o_stat.status     = status;
    assign o_stat.final_byte = is_final;
    assign o_stat.param      = r_param;
    assign o_stat.code       = r_code;

endmodule

// ----- sv/command_frame_builder_checker_top.sv -----
// command_frame_builder_checker_top: input register, dispatch, result register
// depends on cfbc_pkg, cfbc_tx and cfbc_rx
//
// usage
// - input channel (i_in_valid / o_in_stall): each item is a send command
//   (opcode 0, cmd_param and cmd_code) or one received response byte (opcode 1)
// - output channel (o_out_valid / i_out_stall): a send item yields 12 frame
//   bytes, the twelfth flagged with tx_last; the twelfth received byte yields
//   one status item carrying the response parameter and code
// - config channel (i_cfg_valid / o_cfg_ready): writes the 16-bit device id,
//   always ready; write it only while the block is idle
// - path: an item waits in the input register; a frame's first byte then goes
//   through the serializer and the result register, a status straight to it
// - throughput: one received byte per cycle unless a frame or a stalled status
//   holds it; a frame keeps the serializer, the next loads as its last byte goes
// - a receive item waits for an in-flight frame to drain, so results stay in
//   item order
// - reset (synchronous, active low) empties both registers, clears the
//   receiver position and sum, and sets the device id to 1
// - when the receiver stalls, the result register holds, the serializer
//   pauses, and the input register fills and then stalls the sender
module command_frame_builder_checker_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_opcode,
    input  logic [31:0] i_cmd_param,
    input  logic [15:0] i_cmd_code,
    input  logic [7:0]  i_rx_byte,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_result_kind,
    output logic [7:0]  o_tx_byte,
    output logic        o_tx_last,
    output logic [1:0]  o_rx_status,
    output logic [31:0] o_rx_param,
    output logic [15:0] o_rx_code
);

    // device id register
    logic [15:0]        r_device_id;

    // input register
    logic               r_in_vld;
    cfbc_pkg::t_opcode  r_in_op;
    logic [31:0]        r_in_param;
    logic [15:0]        r_in_code;
    logic [7:0]         r_in_byte;

    // result register
    logic               r_out_vld;
    cfbc_pkg::t_kind    r_out_kind;
    logic [7:0]         r_out_byte;
    logic               r_out_last;
    cfbc_pkg::t_status  r_out_status;
    logic [31:0]        r_out_param;
    logic [15:0]        r_out_code;

    cfbc_pkg::t_tx_ctl  tx_ctl;
    cfbc_pkg::t_tx_stat tx_stat;
    cfbc_pkg::t_rx_ctl  rx_ctl;
    cfbc_pkg::t_rx_stat rx_stat;

    logic out_free;     // result register can take a new item this cycle
    logic tx_emit;      // serializer hands a byte to the result register
    logic tx_avail;     // serializer idle or handing over its last byte
    logic go_send;
    logic go_recv;
    logic in_take;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_id <= cfbc_pkg::DEVICE_ID_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_device_id <= i_cfg_data;
        end
    end

    // dispatch out of the input register
    assign out_free = !r_out_vld || !i_out_stall;
    assign tx_emit  = tx_stat.busy && out_free;
    assign tx_avail = !tx_stat.busy || (tx_emit && tx_stat.last);
    assign go_send  = r_in_vld && (r_in_op == cfbc_pkg::OP_SEND) && tx_avail;
    // a status needs the result register; plain bytes only wait for the frame
    assign go_recv  = r_in_vld && (r_in_op == cfbc_pkg::OP_RECV) && !tx_stat.busy
                      && (!rx_stat.final_byte || out_free);

    assign o_in_stall = r_in_vld && !(go_send || go_recv);
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (go_send || go_recv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_op    <= cfbc_pkg::t_opcode'(i_opcode);
            r_in_param <= i_cmd_param;
            r_in_code  <= i_cmd_code;
            r_in_byte  <= i_rx_byte;
        end
    end

    assign tx_ctl.load    = go_send;
    assign tx_ctl.advance = tx_emit;

    cfbc_tx u_tx (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (tx_ctl),
        .i_device_id (r_device_id),
        .i_cmd_param (r_in_param),
        .i_cmd_code  (r_in_code),
        .o_stat      (tx_stat)
    );

    assign rx_ctl.step = go_recv;
    assign rx_ctl.data = r_in_byte;

    cfbc_rx u_rx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (rx_ctl),
        .o_stat  (rx_stat)
    );

    // result register: frame byte, status, or empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= tx_emit || (go_recv && rx_stat.final_byte);
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (tx_emit) begin
                r_out_kind   <= cfbc_pkg::KIND_TX;
                r_out_byte   <= tx_stat.data;
                r_out_last   <= tx_stat.last;
                r_out_status <= cfbc_pkg::ST_OK;
                r_out_param  <= '0;
                r_out_code   <= '0;
            end else begin
                r_out_kind   <= cfbc_pkg::KIND_STATUS;
                r_out_byte   <= '0;
                r_out_last   <= 1'b0;
                r_out_status <= rx_stat.status;
                r_out_param  <= rx_stat.param;
                r_out_code   <= rx_stat.code;
            end
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_result_kind = r_out_kind;
    assign o_tx_byte     = r_out_byte;
    assign o_tx_last     = r_out_last;
    assign o_rx_status   = r_out_status;
    assign o_rx_param    = r_out_param;
    assign o_rx_code     = r_out_code;

    // a loaded frame keeps the serializer busy on the next cycle
    a_send_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go_send |=> tx_stat.busy)
        else $error("send item did not start the serializer");

    // a response byte is never consumed while a frame is still in flight
    a_recv_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tx_stat.busy |-> !rx_ctl.step)
        else $error("response byte taken during a frame");

    // handing over the last byte either idles the serializer or reloads it
    a_tx_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tx_emit && tx_stat.last && !go_send) |=> !tx_stat.busy)
        else $error("serializer did not finish after last byte");

endmodule
